@@ rtl/sequence_extreme_tracker_defines.svh @@
// Assertion macros for the sequence extreme tracker checker.
// Depends on nothing; included by the checker file only.
`ifndef SEQUENCE_EXTREME_TRACKER_DEFINES_SVH
`define SEQUENCE_EXTREME_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define STE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define STE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ste_pkg.sv @@
// Shared sizes, types and opcodes of the sequence extreme tracker.
// Depends on nothing; used by the tracker top level.
`default_nettype none

package ste_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int VALUE_BITS   = 32;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

  typedef logic signed [VALUE_BITS-1:0] val_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [MAX_ELEMENTS-1:0]      mask_t;

  typedef enum logic [2:0] {
    OP_SET    = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_SWAP   = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_DEFINE = 3'd5
  } op_t;

endpackage

`default_nettype wire

@@ rtl/sequence_extreme_tracker.sv @@
// Top level of the sequence extreme tracker: element memory, edit sequencer, rescan.
// Depends on ste_pkg.
`default_nettype none

// Usage
//   A command transaction is taken on the rising edge where start is high and
//   busy is low: op, position, other_position, element_value, is_defined.
//   Exactly one result follows; done is high for one cycle while extreme_value,
//   extreme_defined, tie_mask, element_count and error hold that result. The
//   receiver cannot stall; results must be taken in the done cycle.
//   mode_max is written by cfg_write/cfg_data; the user must write it only
//   while the block is idle, as the block itself does not enforce this.
// Sequencing: every command, rejected ones too, ends with a rescan that reads
//   each held element once. A swap first reads both positions and writes
//   them back crosswise; an insert or remove first moves the elements behind
//   the position, and an insert that moved any then writes the new element.
//   The elements sit in one memory with one read and one write port; every
//   moved element and every scanned element is read through that read port.
//   busy falls in the done cycle, so the next command can be taken then.
// Reset (rst, synchronous) empties the sequence, marks it defined and selects
//   minimum tracking. The memory itself is not cleared: only entries below the
//   element count are ever read, and each was written by an insert.

module sequence_extreme_tracker (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [2:0]          op,
  input  wire logic [3:0]          position,
  input  wire logic [3:0]          other_position,
  input  wire logic signed [31:0]  element_value,
  input  wire logic                is_defined,
  output logic                     busy,
  output logic                     done,
  output logic signed [31:0]       extreme_value,
  output logic                     extreme_defined,
  output logic [15:0]              tie_mask,
  output logic [4:0]               element_count,
  output logic                     error,
  input  wire logic                cfg_write,
  input  wire logic                cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWAP_A,
    S_SWAP_B,
    S_SWAP_C,
    S_SHIFT,
    S_WRITE_NEW,
    S_SCAN
  } state_t;

  state_t           state;
  logic             mode_max;
  ste_pkg::cnt_t    count;
  ste_pkg::mask_t   valid;
  logic             seq_def;

  // latched command
  ste_pkg::op_t     op_q;
  ste_pkg::idx_t    pos_q;
  ste_pkg::idx_t    oth_q;
  ste_pkg::val_t    val_q;
  ste_pkg::val_t    hold;

  // shift pipeline
  ste_pkg::idx_t    rd_ptr;
  ste_pkg::idx_t    rd_end;
  logic             rd_more;
  logic             wr_pend;
  ste_pkg::idx_t    wr_addr;

  // scan pipeline
  ste_pkg::cnt_t    scan_ptr;
  logic             sc_pend;
  ste_pkg::idx_t    sc_idx;
  ste_pkg::val_t    best;
  ste_pkg::mask_t   mask;

  // element memory
  ste_pkg::val_t    mem [ste_pkg::MAX_ELEMENTS];
  ste_pkg::val_t    rdata;
  logic             mem_we;
  ste_pkg::idx_t    mem_waddr;
  ste_pkg::val_t    mem_wdata;
  ste_pkg::idx_t    mem_raddr;

  logic             accept;
  ste_pkg::op_t     op_in;
  ste_pkg::cnt_t    pos_ext;
  ste_pkg::cnt_t    oth_ext;
  ste_pkg::val_t    new_val;
  logic             bad;
  logic             scan_issue;
  logic             better;
  logic             same;
  logic [ste_pkg::MAX_ELEMENTS:0] below_w;
  ste_pkg::mask_t   below;

  assign busy    = (state != S_IDLE);
  assign accept  = start && (state == S_IDLE);
  assign op_in   = ste_pkg::op_t'(op);
  assign pos_ext = ste_pkg::cnt_t'(position);
  assign oth_ext = ste_pkg::cnt_t'(other_position);
  assign new_val = ste_pkg::val_t'(element_value);

  // Check the command against the current count
  always_comb begin
    case (op_in)
      ste_pkg::OP_SET, ste_pkg::OP_REMOVE: bad = (pos_ext >= count);
      ste_pkg::OP_INSERT: bad = (count == ste_pkg::cnt_t'(ste_pkg::MAX_ELEMENTS))
                                || (pos_ext > count);
      ste_pkg::OP_SWAP:   bad = (pos_ext >= count) || (oth_ext >= count);
      default:            bad = 1'b0;
    endcase
  end

  // Scan compare against the running extreme
  assign scan_issue = (scan_ptr < count);
  assign better     = mode_max ? (rdata > best) : (rdata < best);
  assign same       = (rdata == best);
  assign below_w    = ({{ste_pkg::MAX_ELEMENTS{1'b0}}, 1'b1} << count) - 1'b1;
  assign below      = below_w[ste_pkg::MAX_ELEMENTS-1:0];

  // Drive the memory ports from the sequencer state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = rdata;
    mem_raddr = position;
    unique case (state)
      S_IDLE: begin
        if (accept && !bad && ((op_in == ste_pkg::OP_SET) ||
            ((op_in == ste_pkg::OP_INSERT) && (pos_ext == count)))) begin
          mem_we    = 1'b1;
          mem_waddr = position;
          mem_wdata = new_val;
        end
      end
      S_SWAP_A: mem_raddr = oth_q;
      S_SWAP_B: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = rdata;
      end
      S_SWAP_C: begin
        mem_we    = 1'b1;
        mem_waddr = oth_q;
        mem_wdata = hold;
      end
      S_SHIFT: begin
        mem_we    = wr_pend;
        mem_raddr = rd_ptr;
      end
      S_WRITE_NEW: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = val_q;
      end
      S_SCAN: mem_raddr = scan_ptr[ste_pkg::IDX_W-1:0];
      default: mem_raddr = position;
    endcase
  end

  // Element memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Sequencer, flags and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode_max <= 1'b0;
      count    <= '0;
      valid    <= '0;
      seq_def  <= 1'b1;
      done     <= 1'b0;
      rd_more  <= 1'b0;
      wr_pend  <= 1'b0;
      sc_pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        mode_max <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q     <= op_in;
            pos_q    <= position;
            oth_q    <= other_position;
            val_q    <= new_val;
            error    <= bad;
            scan_ptr <= '0;
            sc_pend  <= 1'b0;
            mask     <= '0;
            wr_pend  <= 1'b0;
            state    <= S_SCAN;
            if (!bad) begin
              case (op_in)
                ste_pkg::OP_SET: valid[position] <= is_defined;
                ste_pkg::OP_INSERT: begin
                  for (int i = 1; i < ste_pkg::MAX_ELEMENTS; i++) begin
                    if ((i > int'(position)) && (i <= int'(count))) begin
                      valid[i] <= valid[i-1];
                    end
                  end
                  valid[position] <= is_defined;
                  count <= count + 1'b1;
                  if (pos_ext != count) begin
                    rd_ptr  <= ste_pkg::idx_t'(count - 1'b1);
                    rd_end  <= position;
                    rd_more <= 1'b1;
                    state   <= S_SHIFT;
                  end
                end
                ste_pkg::OP_REMOVE: begin
                  for (int i = 0; i < ste_pkg::MAX_ELEMENTS - 1; i++) begin
                    if ((i >= int'(position)) && (i + 1 < int'(count))) begin
                      valid[i] <= valid[i+1];
                    end
                  end
                  valid[ste_pkg::idx_t'(count - 1'b1)] <= 1'b0;
                  count <= count - 1'b1;
                  if (pos_ext + 1'b1 != count) begin
                    rd_ptr  <= position + 1'b1;
                    rd_end  <= ste_pkg::idx_t'(count - 1'b1);
                    rd_more <= 1'b1;
                    state   <= S_SHIFT;
                  end
                end
                ste_pkg::OP_SWAP: begin
                  valid[position]       <= valid[other_position];
                  valid[other_position] <= valid[position];
                  state                 <= S_SWAP_A;
                end
                ste_pkg::OP_CLEAR: begin
                  count <= '0;
                  valid <= '0;
                end
                ste_pkg::OP_DEFINE: seq_def <= is_defined;
                default: ;
              endcase
            end
          end
        end
        S_SWAP_A: begin
          hold  <= rdata;
          state <= S_SWAP_B;
        end
        S_SWAP_B: state <= S_SWAP_C;
        S_SWAP_C: state <= S_SCAN;
        // Move one element per cycle: read ahead, write the previous read
        S_SHIFT: begin
          wr_pend <= rd_more;
          if (rd_more) begin
            wr_addr <= (op_q == ste_pkg::OP_INSERT) ? rd_ptr + 1'b1 : rd_ptr - 1'b1;
            if (rd_ptr == rd_end) begin
              rd_more <= 1'b0;
            end else begin
              rd_ptr <= (op_q == ste_pkg::OP_INSERT) ? rd_ptr - 1'b1 : rd_ptr + 1'b1;
            end
          end else begin
            state <= (op_q == ste_pkg::OP_INSERT) ? S_WRITE_NEW : S_SCAN;
          end
        end
        S_WRITE_NEW: state <= S_SCAN;
        // Read each element once and fold each defined one into the extreme and tie mask
        S_SCAN: begin
          if (scan_issue) begin
            scan_ptr <= scan_ptr + 1'b1;
          end
          sc_pend <= scan_issue;
          sc_idx  <= scan_ptr[ste_pkg::IDX_W-1:0];
          if (sc_pend && valid[sc_idx]) begin
            if ((mask == '0) || better) begin
              best <= rdata;
              mask <= ste_pkg::mask_t'(1) << sc_idx;
            end else if (same) begin
              mask[sc_idx] <= 1'b1;
            end
          end
          if (!scan_issue && !sc_pend) begin
            done            <= 1'b1;
            extreme_value   <= (mask != '0) ? 32'(best) : '0;
            extreme_defined <= seq_def && (count != '0) && ((valid & below) == below);
            tie_mask        <= 16'(mask);
            element_count   <= 5'(count);
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/ste_checker.sv @@
// Port-level checker for the sequence extreme tracker, bound to the top level.
// Depends on sequence_extreme_tracker_defines.svh and sequence_extreme_tracker.
`default_nettype none
`include "sequence_extreme_tracker_defines.svh"

module ste_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done,
  input wire logic signed [31:0] extreme_value,
  input wire logic               extreme_defined,
  input wire logic [15:0]        tie_mask,
  input wire logic [4:0]         element_count
);

  logic [16:0] above_count;

  // Tie bits at or above the element count
  assign above_count = {1'b0, tie_mask} >> element_count;

  // An accepted transaction is followed by busy, with no result yet
  `STE_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accept not followed by busy")
  // A result strobe lasts one cycle
  `STE_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  // No tie bit past the end of the sequence, and a count of at most 16
  `STE_ASSERT_NOW(a_mask_in_range, done, (above_count == 17'd0) && (element_count <= 5'd16),
                  "tie mask or count out of range")
  // No tied position means no extreme value and no defined extreme
  `STE_ASSERT_NOW(a_empty_mask, done && (tie_mask == 16'd0),
                  (extreme_value == 32'sd0) && !extreme_defined, "empty mask with extreme")

endmodule

bind sequence_extreme_tracker ste_checker u_ste_checker (.*);

`default_nettype wire

@@ test/tb_sequence_extreme_tracker.sv @@
// Testbench for sequence_extreme_tracker: edits an element sequence, predicts each result.
// Depends on ste_pkg and the sequence_extreme_tracker top level.
`timescale 1ns / 1ps

module tb_sequence_extreme_tracker;

  // Opcodes outside op_t that the block must ignore
  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef struct {
    ste_pkg::val_t  value;
    logic           defined;
    ste_pkg::mask_t mask;
    ste_pkg::cnt_t  count;
    logic           err;
  } tracker_result_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  logic [2:0]     op = '0;
  ste_pkg::idx_t  position = '0;
  ste_pkg::idx_t  other_position = '0;
  ste_pkg::val_t  element_value = '0;
  logic           is_defined = 1'b0;
  logic           cfg_write = 1'b0;
  logic           cfg_data = 1'b0;
  logic           busy;
  logic           done;
  ste_pkg::val_t  extreme_value;
  logic           extreme_defined;
  ste_pkg::mask_t tie_mask;
  ste_pkg::cnt_t  element_count;
  logic           error;

  // Shadow copy of the tracker state
  ste_pkg::val_t  seq_vals [ste_pkg::MAX_ELEMENTS];
  logic           seq_defs [ste_pkg::MAX_ELEMENTS];
  int             seq_len = 0;
  logic           seq_defined = 1'b1;
  ste_pkg::val_t  cur_extreme = '0;
  logic           track_max = 1'b0;

  tracker_result_t pending_results[$];
  int mismatch_count = 0;

  sequence_extreme_tracker DUT (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .op              (op),
    .position        (position),
    .other_position  (other_position),
    .element_value   (element_value),
    .is_defined      (is_defined),
    .busy            (busy),
    .done            (done),
    .extreme_value   (extreme_value),
    .extreme_defined (extreme_defined),
    .tie_mask        (tie_mask),
    .element_count   (element_count),
    .error           (error),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < ste_pkg::MAX_ELEMENTS; i++) begin
      seq_vals[i] = '0;
      seq_defs[i] = 1'b0;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Apply one edit to the shadow state and return the result it produces
  function automatic tracker_result_t apply_edit(input logic [2:0] cmd,
                                                 input ste_pkg::idx_t p,
                                                 input ste_pkg::idx_t q,
                                                 input ste_pkg::val_t v, input logic d);
    tracker_result_t r;
    logic           rejected;
    ste_pkg::val_t  tv;
    logic           td;
    ste_pkg::mask_t m;
    ste_pkg::val_t  best;
    logic           all_def;
    rejected = 1'b0;
    case (cmd)
      ste_pkg::OP_SET: begin
        if (int'(p) >= seq_len) begin
          rejected = 1'b1;
        end else begin
          seq_vals[p] = v;
          seq_defs[p] = d;
        end
      end
      ste_pkg::OP_INSERT: begin
        if (seq_len >= ste_pkg::MAX_ELEMENTS || int'(p) > seq_len) begin
          rejected = 1'b1;
        end else begin
          for (int i = seq_len; i > int'(p); i--) begin
            seq_vals[i] = seq_vals[i-1];
            seq_defs[i] = seq_defs[i-1];
          end
          seq_vals[p] = v;
          seq_defs[p] = d;
          seq_len++;
        end
      end
      ste_pkg::OP_REMOVE: begin
        if (int'(p) >= seq_len) begin
          rejected = 1'b1;
        end else begin
          for (int i = int'(p); i + 1 < seq_len; i++) begin
            seq_vals[i] = seq_vals[i+1];
            seq_defs[i] = seq_defs[i+1];
          end
          seq_len--;
          seq_vals[seq_len] = '0;
          seq_defs[seq_len] = 1'b0;
        end
      end
      ste_pkg::OP_SWAP: begin
        if (int'(p) >= seq_len || int'(q) >= seq_len) begin
          rejected = 1'b1;
        end else begin
          tv = seq_vals[p];
          td = seq_defs[p];
          seq_vals[p] = seq_vals[q];
          seq_defs[p] = seq_defs[q];
          seq_vals[q] = tv;
          seq_defs[q] = td;
        end
      end
      ste_pkg::OP_CLEAR: begin
        seq_len = 0;
        for (int i = 0; i < ste_pkg::MAX_ELEMENTS; i++) begin
          seq_vals[i] = '0;
          seq_defs[i] = 1'b0;
        end
      end
      ste_pkg::OP_DEFINE: seq_defined = d;
      default: ;
    endcase

    // Rescan every defined element for the extreme and its ties
    m = '0;
    best = cur_extreme;
    all_def = 1'b1;
    for (int i = 0; i < seq_len; i++) begin
      if (!seq_defs[i]) begin
        all_def = 1'b0;
      end else if (m == '0 || (track_max ? (seq_vals[i] > best) : (seq_vals[i] < best))) begin
        best = seq_vals[i];
        m = ste_pkg::mask_t'(1) << i;
      end else if (seq_vals[i] == best) begin
        m[i] = 1'b1;
      end
    end
    if (m != '0) cur_extreme = best;

    r.value   = (m != '0) ? cur_extreme : '0;
    r.defined = seq_defined && all_def && (seq_len > 0);
    r.mask    = m;
    r.count   = ste_pkg::cnt_t'(seq_len);
    r.err     = rejected;
    return r;
  endfunction

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Small values give ties; the rest are extremes or full-range values
  function automatic ste_pkg::val_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return ste_pkg::val_t'(int'($urandom_range(0, 6)) - 3);
    if (r < 60) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7fffffff;
        1: return 32'sh80000000;
        2: return '0;
        default: return '1;
      endcase
    end
    return ste_pkg::val_t'($urandom);
  endfunction

  // Drive one command transaction, hold until taken, then optionally idle
  task automatic send_edit(input logic [2:0] cmd, input ste_pkg::idx_t p,
                           input ste_pkg::idx_t q, input ste_pkg::val_t v,
                           input logic d, input bit idle_ok);
    int gap;
    start          <= 1'b1;
    op             <= cmd;
    position       <= p;
    other_position <= q;
    element_value  <= v;
    is_defined     <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_edit(cmd, p, q, v, d));
    gap = idle_ok ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every pending result has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    track_max = mode;
    cfg_write <= 1'b0;
  endtask

  // One random edit: mostly well-formed positions, some noise
  task automatic random_edit(input bit idle_ok);
    int            r;
    logic [2:0]    cmd;
    ste_pkg::idx_t p;
    ste_pkg::idx_t q;
    ste_pkg::val_t v;
    logic          d;
    r = $urandom_range(0, 99);
    if (r < 30)      cmd = ste_pkg::OP_INSERT;
    else if (r < 50) cmd = ste_pkg::OP_SET;
    else if (r < 68) cmd = ste_pkg::OP_REMOVE;
    else if (r < 83) cmd = ste_pkg::OP_SWAP;
    else if (r < 86) cmd = ste_pkg::OP_CLEAR;
    else if (r < 92) cmd = ste_pkg::OP_DEFINE;
    else if (r < 95) cmd = $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;
    else             cmd = 3'($urandom_range(0, 7));
    if (r >= 95 || $urandom_range(0, 99) < 8 ||
        (seq_len == 0 && cmd != ste_pkg::OP_INSERT)) begin
      p = ste_pkg::idx_t'($urandom_range(0, 15));
      q = ste_pkg::idx_t'($urandom_range(0, 15));
    end else if (cmd == ste_pkg::OP_INSERT) begin
      p = ste_pkg::idx_t'($urandom_range(0, (seq_len < 16) ? seq_len : 15));
      q = ste_pkg::idx_t'($urandom_range(0, 15));
    end else begin
      p = ste_pkg::idx_t'($urandom_range(0, seq_len - 1));
      q = ste_pkg::idx_t'($urandom_range(0, seq_len - 1));
    end
    v = pick_value();
    d = (cmd == ste_pkg::OP_DEFINE) ? ($urandom_range(0, 3) != 0)
                                    : ($urandom_range(0, 9) != 0);
    send_edit(cmd, p, q, v, d, idle_ok);
  endtask

  // Compare each strobed result with the oldest prediction
  always @(posedge clk) begin : check_results
    tracker_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result strobed with no transaction pending");
      end else begin
        want = pending_results.pop_front();
        if (extreme_value !== want.value)
          report_mismatch($sformatf("extreme_value got %0d want %0d", extreme_value, want.value));
        if (extreme_defined !== want.defined)
          report_mismatch($sformatf("extreme_defined got %b want %b",
                                    extreme_defined, want.defined));
        if (tie_mask !== want.mask)
          report_mismatch($sformatf("tie_mask got %h want %h", tie_mask, want.mask));
        if (element_count !== want.count)
          report_mismatch($sformatf("element_count got %0d want %0d",
                                    element_count, want.count));
        if (error !== want.err)
          report_mismatch($sformatf("error got %b want %b", error, want.err));
      end
    end
  end

  // Extreme values, ties, every op, bad positions, undefined elements and sequence
  task automatic test_directed_edits();
    send_edit(ste_pkg::OP_SET,    4'd0, 4'd0, 32'sd9,          1'b1, 1);
    send_edit(ste_pkg::OP_INSERT, 4'd0, 4'd0, 32'sh7fffffff,   1'b1, 1);
    send_edit(ste_pkg::OP_INSERT, 4'd0, 4'd0, 32'sh80000000,   1'b1, 1);
    send_edit(ste_pkg::OP_INSERT, 4'd2, 4'd0, 32'sd0,          1'b1, 1);
    send_edit(ste_pkg::OP_INSERT, 4'd1, 4'd0, 32'sh80000000,   1'b1, 1);
    send_edit(ste_pkg::OP_INSERT, 4'd5, 4'd0, 32'sd1,          1'b1, 1);
    send_edit(ste_pkg::OP_SET,    4'd3, 4'd0, '1,              1'b0, 1);
    send_edit(ste_pkg::OP_SWAP,   4'd0, 4'd3, 32'sd0,          1'b0, 1);
    send_edit(ste_pkg::OP_SWAP,   4'd1, 4'd15, 32'sd0,         1'b0, 1);
    send_edit(ste_pkg::OP_REMOVE, 4'd0, 4'd0, 32'sd0,          1'b0, 1);
    send_edit(ste_pkg::OP_REMOVE, 4'd3, 4'd0, 32'sd0,          1'b0, 1);
    send_edit(ste_pkg::OP_DEFINE, 4'd0, 4'd0, 32'sd0,          1'b0, 1);
    send_edit(ste_pkg::OP_SET,    4'd2, 4'd0, 32'sh7fffffff,   1'b1, 1);
    send_edit(ste_pkg::OP_DEFINE, 4'd15, 4'd15, '1,            1'b1, 1);
    send_edit(OP_UNUSED_LO,       4'd15, 4'd15, '1,            1'b1, 1);
    send_edit(OP_UNUSED_HI,       4'd0, 4'd0, 32'sd0,          1'b0, 1);
    send_edit(ste_pkg::OP_SET,    4'd0, 4'd0, 32'sd4,          1'b0, 1);
    send_edit(ste_pkg::OP_SET,    4'd1, 4'd0, 32'sd4,          1'b0, 1);
    send_edit(ste_pkg::OP_SET,    4'd2, 4'd0, 32'sd4,          1'b0, 1);
    send_edit(ste_pkg::OP_CLEAR,  4'd15, 4'd15, '1,            1'b1, 1);
    send_edit(ste_pkg::OP_REMOVE, 4'd0, 4'd0, 32'sd0,          1'b1, 1);
    send_edit(ste_pkg::OP_SWAP,   4'd0, 4'd0, 32'sd0,          1'b1, 1);
    send_edit(ste_pkg::OP_INSERT, 4'd0, 4'd0, '1,              1'b0, 1);
    send_edit(ste_pkg::OP_INSERT, 4'd1, 4'd0, 32'sd5,          1'b1, 1);
  endtask

  // Fill from the front (longest shifts), overflow, drop the last slot, then swap two
  task automatic test_fill_and_overflow();
    write_mode(1'b1);
    send_edit(ste_pkg::OP_CLEAR, 4'd0, 4'd0, 32'sd0, 1'b0, 1);
    for (int i = 0; i < ste_pkg::MAX_ELEMENTS; i++)
      send_edit(ste_pkg::OP_INSERT, 4'd0, 4'd0, pick_value(), 1'b1, 1);
    send_edit(ste_pkg::OP_INSERT, 4'd0, 4'd0, 32'sd1, 1'b1, 1);
    send_edit(ste_pkg::OP_INSERT, 4'd15, 4'd0, 32'sd1, 1'b1, 1);
    send_edit(ste_pkg::OP_REMOVE, 4'd15, 4'd0, 32'sd0, 1'b0, 1);
    send_edit(ste_pkg::OP_SWAP,   4'd0, 4'd14, 32'sd0, 1'b0, 1);
  endtask

  task automatic test_min_tracking();
    write_mode(1'b0);
    repeat (450) random_edit(1);
  endtask

  task automatic test_max_tracking();
    write_mode(1'b1);
    repeat (450) random_edit(1);
  endtask

  // Keep start high between transactions: no sender idling at all
  task automatic test_back_to_back();
    write_mode(1'b0);
    repeat (200) random_edit(0);
  endtask

  // Stop sending every so often until the block has delivered everything
  task automatic test_sender_pause();
    write_mode(1'b1);
    for (int i = 0; i < 150; i++) begin
      random_edit(1);
      if (i % 30 == 29) wait_drained();
    end
  endtask

  initial begin : run_tests
    int drain_cycles;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edits();
    test_fill_and_overflow();
    test_min_tracking();
    test_max_tracking();
    test_back_to_back();
    test_sender_pause();

    // Drain, then allow for the longest command latency
    start <= 1'b0;
    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
